### hdl/bgsd_pkg.sv
// ============================================================================
// bgsd_pkg: shared types, constants and functions for the battery gauge
// Segment codes, level bar thresholds and the digit bundle that goes to the
// segment encoder.
// ============================================================================
`default_nettype none

package bgsd_pkg;

    // millivolt reading at which the charge percent scale starts from zero
    localparam logic [13:0] MV_FLOOR    = 14'd3000;
    localparam logic [6:0]  PCT_FULL    = 7'd100;

    // reciprocal multipliers for exact constant division
    localparam logic [15:0] RECIP_TEN     = 16'd52429;  // x/10  = (x*52429) >> 19, x < 43690
    localparam logic [12:0] RECIP_HUNDRED = 13'd5243;   // x/100 = (x*5243)  >> 19, x < 2048
    localparam logic [7:0]  RECIP_TEN_LO  = 8'd205;     // x/10  = (x*205)   >> 11, x < 128

    // indicator codes
    localparam logic [2:0] IND_PERCENT = 3'b001;
    localparam logic [2:0] IND_VOLTS   = 3'b110;

    // seven-segment codes, segments g..a
    localparam logic [6:0] SEG_0 = 7'b0111111;
    localparam logic [6:0] SEG_1 = 7'b0000110;
    localparam logic [6:0] SEG_2 = 7'b1011011;
    localparam logic [6:0] SEG_3 = 7'b1001111;
    localparam logic [6:0] SEG_4 = 7'b1100110;
    localparam logic [6:0] SEG_5 = 7'b1101101;
    localparam logic [6:0] SEG_6 = 7'b1111101;
    localparam logic [6:0] SEG_7 = 7'b0000111;
    localparam logic [6:0] SEG_8 = 7'b1111111;
    localparam logic [6:0] SEG_9 = 7'b1101111;
    localparam logic [6:0] SEG_OFF = 7'b0000000;

    // digits and flags handed to the segment encoder
    typedef struct packed {
        logic       pct_mode;  // 1: percent indicator, else volts
        logic [4:0] bar;
        logic       blank0;    // hundreds digit dark
        logic       blank1;    // tens digit dark
        logic [3:0] d0;
        logic [3:0] d1;
        logic [3:0] d2;
    } digit_set_t;

    function automatic logic [6:0] seg7(input logic [3:0] d);
        logic [6:0] s;
        case (d)
            4'd0:    s = SEG_0;
            4'd1:    s = SEG_1;
            4'd2:    s = SEG_2;
            4'd3:    s = SEG_3;
            4'd4:    s = SEG_4;
            4'd5:    s = SEG_5;
            4'd6:    s = SEG_6;
            4'd7:    s = SEG_7;
            4'd8:    s = SEG_8;
            4'd9:    s = SEG_9;
            default: s = SEG_OFF;
        endcase
        return s;
    endfunction

    // thermometer bar: 5, 30, 50, 70, 90 percent
    function automatic logic [4:0] level_bar(input logic [6:0] pct);
        logic [4:0] b;
        b = {pct >= 7'd90, pct >= 7'd70, pct >= 7'd50, pct >= 7'd30, pct >= 7'd5};
        return b;
    endfunction

endpackage

`default_nettype wire

### hdl/bgsd_encode.sv
// ============================================================================
// bgsd_encode: display word packer
// Turns the bar, three digits with blanking flags and the mode into the
// 29-bit segment word.
// ============================================================================
`default_nettype none

module bgsd_encode (
    input  wire bgsd_pkg::digit_set_t ds,
    output logic [28:0]               word
);

    logic [6:0] seg0;
    logic [6:0] seg1;
    logic [6:0] seg2;
    logic [2:0] ind;

    // digit segments with leading blanking
    always_comb begin
        seg0 = ds.blank0 ? bgsd_pkg::SEG_OFF : bgsd_pkg::seg7(ds.d0);
        seg1 = ds.blank1 ? bgsd_pkg::SEG_OFF : bgsd_pkg::seg7(ds.d1);
        seg2 = bgsd_pkg::seg7(ds.d2);
        ind  = ds.pct_mode ? bgsd_pkg::IND_PERCENT : bgsd_pkg::IND_VOLTS;
    end

    assign word = {ds.bar, seg0, seg1, seg2, ind};

endmodule

`default_nettype wire

### hdl/battery_gauge_segment_display.sv
// Throughput: one word per cycle while the output is not stalled by m_tready;
// six register stages, at most one constant multiply each.
// Each stage advances when the stage after it is empty or moving, so bubbles
// close up behind a stalled output and s_tready drops only when all stages are full.
// Reset: aresetn (synchronous, active low) clears all stage valid bits; payload
// registers are not reset.
// ============================================================================
// battery_gauge_segment_display: battery meter with seven-segment output
// Converts a signed sample into millivolts, charge percent and a segment word
// showing a level bar and either percent or volts to hundredths.
// ============================================================================
`default_nettype none

module battery_gauge_segment_display (
    input  wire         aclk,
    input  wire         aresetn,
    // s_tdata: [15:0] voltage_reading (signed), [23:16] status_byte
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,
    // m_tdata: [28:0] display_word, [29] read_error, [43:30] millivolts,
    //          [50:44] charge_percent, [55:51] zero
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [55:0] m_tdata
);

    localparam int NUM_STAGES = 6;

    // fields that ride along through every stage
    typedef struct packed {
        logic        err;
        logic        pct_mode;
        logic [13:0] mv;
        logic [6:0]  pct;
    } ctx_t;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] adv;

    // pipeline flow control
    always_comb begin
        adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        valid_next[0] = adv[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            valid_next[k] = adv[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = adv[0];

    // ---------------------------------------------------------------- stage 1
    // millivolts, percent, mv/10
    ctx_t        s1_ctx_next, s1_ctx_reg;
    logic [10:0] s1_q_next, s1_q_reg;
    logic [29:0] s1_prod;
    logic [13:0] s1_diff;

    always_comb begin
        s1_ctx_next.err      = s_tdata[15];
        s1_ctx_next.pct_mode = s_tdata[20];
        s1_ctx_next.mv       = s_tdata[14:1];
        s1_diff              = s_tdata[14:1] - bgsd_pkg::MV_FLOOR;
        if (s_tdata[14:1] < bgsd_pkg::MV_FLOOR) begin
            s1_ctx_next.pct = '0;
        end else if (s1_diff[13:3] > {4'd0, bgsd_pkg::PCT_FULL}) begin
            s1_ctx_next.pct = bgsd_pkg::PCT_FULL;
        end else begin
            s1_ctx_next.pct = s1_diff[9:3];
        end
        s1_prod   = {16'd0, s_tdata[14:1]} * {14'd0, bgsd_pkg::RECIP_TEN};
        s1_q_next = s1_prod[29:19];
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            s1_ctx_reg <= s1_ctx_next;
            s1_q_reg   <= s1_q_next;
        end
    end

    // ---------------------------------------------------------------- stage 2
    // rounded centivolts, bar, percent tens
    ctx_t        s2_ctx_reg;
    logic [10:0] s2_cv_next, s2_cv_reg;
    logic [4:0]  s2_bar_next, s2_bar_reg;
    logic [3:0]  s2_pt_next, s2_pt_reg;
    logic [13:0] s2_rem;
    logic [14:0] s2_prod;

    always_comb begin
        s2_rem      = s1_ctx_reg.mv - ({s1_q_reg, 3'b000} + {2'b00, s1_q_reg, 1'b0});
        s2_cv_next  = s1_q_reg + ((s2_rem >= 14'd5) ? 11'd1 : 11'd0);
        s2_bar_next = bgsd_pkg::level_bar(s1_ctx_reg.pct);
        s2_prod     = {8'd0, s1_ctx_reg.pct} * {7'd0, bgsd_pkg::RECIP_TEN_LO};
        s2_pt_next  = s2_prod[14:11];
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            s2_ctx_reg <= s1_ctx_reg;
            s2_cv_reg  <= s2_cv_next;
            s2_bar_reg <= s2_bar_next;
            s2_pt_reg  <= s2_pt_next;
        end
    end

    // ---------------------------------------------------------------- stage 3
    // volts digit, percent ones
    ctx_t        s3_ctx_reg;
    logic [10:0] s3_cv_reg;
    logic [4:0]  s3_bar_reg;
    logic [3:0]  s3_pt_reg;
    logic [4:0]  s3_h_next, s3_h_reg;
    logic [3:0]  s3_po_next, s3_po_reg;
    logic [23:0] s3_prod;
    logic [6:0]  s3_po_full;

    always_comb begin
        s3_prod    = {13'd0, s2_cv_reg} * {11'd0, bgsd_pkg::RECIP_HUNDRED};
        s3_h_next  = s3_prod[23:19];
        s3_po_full = s2_ctx_reg.pct - ({s2_pt_reg, 3'b000} + {2'b00, s2_pt_reg, 1'b0});
        s3_po_next = s3_po_full[3:0];
    end

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            s3_ctx_reg <= s2_ctx_reg;
            s3_cv_reg  <= s2_cv_reg;
            s3_bar_reg <= s2_bar_reg;
            s3_pt_reg  <= s2_pt_reg;
            s3_h_reg   <= s3_h_next;
            s3_po_reg  <= s3_po_next;
        end
    end

    // ---------------------------------------------------------------- stage 4
    // centivolts below one volt
    ctx_t        s4_ctx_reg;
    logic [4:0]  s4_bar_reg;
    logic [3:0]  s4_pt_reg;
    logic [3:0]  s4_po_reg;
    logic [4:0]  s4_h_reg;
    logic [6:0]  s4_rest_next, s4_rest_reg;
    logic [10:0] s4_rest_full;

    always_comb begin
        s4_rest_full = s3_cv_reg - ({s3_h_reg, 6'd0} + {1'b0, s3_h_reg, 5'd0}
                                    + {4'd0, s3_h_reg, 2'd0});
        s4_rest_next = s4_rest_full[6:0];
    end

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            s4_ctx_reg  <= s3_ctx_reg;
            s4_bar_reg  <= s3_bar_reg;
            s4_pt_reg   <= s3_pt_reg;
            s4_po_reg   <= s3_po_reg;
            s4_h_reg    <= s3_h_reg;
            s4_rest_reg <= s4_rest_next;
        end
    end

    // ---------------------------------------------------------------- stage 5
    // tenths of a volt
    ctx_t        s5_ctx_reg;
    logic [4:0]  s5_bar_reg;
    logic [3:0]  s5_pt_reg;
    logic [3:0]  s5_po_reg;
    logic [4:0]  s5_h_reg;
    logic [6:0]  s5_rest_reg;
    logic [3:0]  s5_vt_next, s5_vt_reg;
    logic [14:0] s5_prod;

    always_comb begin
        s5_prod    = {8'd0, s4_rest_reg} * {7'd0, bgsd_pkg::RECIP_TEN_LO};
        s5_vt_next = s5_prod[14:11];
    end

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            s5_ctx_reg  <= s4_ctx_reg;
            s5_bar_reg  <= s4_bar_reg;
            s5_pt_reg   <= s4_pt_reg;
            s5_po_reg   <= s4_po_reg;
            s5_h_reg    <= s4_h_reg;
            s5_rest_reg <= s4_rest_reg;
            s5_vt_reg   <= s5_vt_next;
        end
    end

    // ---------------------------------------------------------------- stage 6
    // digit select, segment encode, output register
    bgsd_pkg::digit_set_t s6_ds;
    logic [6:0]  s6_vo_full;
    logic        s6_hund;
    logic [3:0]  s6_ptens;
    logic [28:0] s6_word;
    logic [55:0] m_tdata_next, m_tdata_reg;

    always_comb begin
        s6_vo_full     = s5_rest_reg - ({s5_vt_reg, 3'b000} + {2'b00, s5_vt_reg, 1'b0});
        s6_hund        = (s5_ctx_reg.pct == bgsd_pkg::PCT_FULL);
        s6_ptens       = s6_hund ? 4'd0 : s5_pt_reg;
        s6_ds.pct_mode = s5_ctx_reg.pct_mode;
        s6_ds.bar      = s5_bar_reg;
        if (s5_ctx_reg.pct_mode) begin
            s6_ds.blank0 = !s6_hund;
            s6_ds.blank1 = !s6_hund && (s6_ptens == 4'd0);
            s6_ds.d0     = {3'd0, s6_hund};
            s6_ds.d1     = s6_ptens;
            s6_ds.d2     = s5_po_reg;
        end else if (s5_h_reg > 5'd9) begin
            // ten volts and up: pin at 9.99
            s6_ds.blank0 = 1'b0;
            s6_ds.blank1 = 1'b0;
            s6_ds.d0     = 4'd9;
            s6_ds.d1     = 4'd9;
            s6_ds.d2     = 4'd9;
        end else begin
            s6_ds.blank0 = 1'b0;
            s6_ds.blank1 = 1'b0;
            s6_ds.d0     = s5_h_reg[3:0];
            s6_ds.d1     = s5_vt_reg;
            s6_ds.d2     = s6_vo_full[3:0];
        end
    end

    bgsd_encode u_encode (
        .ds   (s6_ds),
        .word (s6_word)
    );

    // negative sample: only the error flag survives
    always_comb begin
        if (s5_ctx_reg.err) begin
            m_tdata_next = {5'd0, 7'd0, 14'd0, 1'b1, 29'd0};
        end else begin
            m_tdata_next = {5'd0, s5_ctx_reg.pct, s5_ctx_reg.mv, 1'b0, s6_word};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------- assertions
    // an error word carries nothing else
    a_err_clean : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[29] |-> m_tdata[28:0] == 29'd0 && m_tdata[55:30] == 26'd0)
        else $error("error word has stray payload");

    // charge never exceeds full scale
    a_pct_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[50:44] <= bgsd_pkg::PCT_FULL)
        else $error("charge percent above 100");

    // good words carry a valid indicator
    a_ind_code : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[29] |->
            m_tdata[2:0] == bgsd_pkg::IND_PERCENT || m_tdata[2:0] == bgsd_pkg::IND_VOLTS)
        else $error("bad indicator code");

    // input held off only when every stage is occupied
    a_full_stall : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> &valid_reg)
        else $error("input stalled with a bubble in the pipeline");

    // a stalled output word stays put and the stage keeps its valid
    a_out_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata_reg))
        else $error("output word lost under stall");

endmodule

`default_nettype wire
